// ===== rtl/fifo_handle_allocator_top_assert.svh =====
// Assertion macros shared by the checkers of the handle allocator.
`ifndef FIFO_HANDLE_ALLOCATOR_TOP_ASSERT_SVH
`define FIFO_HANDLE_ALLOCATOR_TOP_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define FHA_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("handle allocator check failed");

// A condition that must be followed by another one at the next edge.
`define FHA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("handle allocator sequence check failed");

`endif

// ===== rtl/fha_pkg.sv =====
// Types and constants shared by the handle allocator modules.
`timescale 1ns / 1ps

package fha_pkg;

    localparam int HANDLE_COUNT = 64;
    localparam int IDX_W        = (HANDLE_COUNT > 1) ? $clog2(HANDLE_COUNT) : 1;
    localparam int CNT_W        = $clog2(HANDLE_COUNT + 1);
    localparam int HANDLE_W     = 32;
    localparam int BASE_W       = 31;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_NO_RESOURCE = 2'd1,
        ST_INVALID     = 2'd2
    } status_t;

    typedef enum logic {
        REQ_OPEN  = 1'b0,
        REQ_CLOSE = 1'b1
    } req_type_t;

    typedef logic [IDX_W-1:0] idx_t;

    // Control from the allocator engine to the free queue store.
    typedef struct packed {
        logic push;
        idx_t waddr;
        idx_t wdata;
        idx_t raddr;
    } fq_ctrl_t;

endpackage

// ===== rtl/fha_if.sv =====
// Request and response channel interfaces of the handle allocator.
`timescale 1ns / 1ps

interface fha_req_if;
    logic                                   valid;
    logic                                   ready;
    fha_pkg::req_type_t                     req_type;
    logic signed [fha_pkg::HANDLE_W-1:0]    handle;

    modport source (output valid, output req_type, output handle, input ready);
    modport sink   (input valid, input req_type, input handle, output ready);
endinterface

interface fha_rsp_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [fha_pkg::HANDLE_W-1:0]    handle_out;
    fha_pkg::status_t                       status;

    modport source (output valid, output handle_out, output status, input ready);
    modport sink   (input valid, input handle_out, input status, output ready);
endinterface

// ===== rtl/fha_free_queue.sv =====
// Storage of the free pool indices with a registered head read port.
`timescale 1ns / 1ps

module fha_free_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  fha_pkg::fq_ctrl_t ctrl,
    output fha_pkg::idx_t     head_entry
);

    fha_pkg::idx_t                  mem [fha_pkg::HANDLE_COUNT];
    logic [fha_pkg::HANDLE_COUNT-1:0] written_reg;
    fha_pkg::idx_t                  rd_data_reg;
    logic                           rd_written_reg;
    fha_pkg::idx_t                  rd_addr_reg;
    logic                           bypass;

    // A transfer written at the address being read this cycle is forwarded.
    assign bypass = ctrl.push && (ctrl.waddr == ctrl.raddr);

    // Entry store, written at the tail.
    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            mem[ctrl.waddr] <= ctrl.wdata;
        end
    end

    // Registered read of the next head entry.
    always_ff @(posedge clk)
    begin
        if (bypass)
        begin
            rd_data_reg <= ctrl.wdata;
        end
        else
        begin
            rd_data_reg <= mem[ctrl.raddr];
        end
    end

    // Written flags and the read address; an unwritten entry holds its own index.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg    <= '0;
            rd_written_reg <= 1'b0;
            rd_addr_reg    <= '0;
        end
        else
        begin
            if (ctrl.push)
            begin
                written_reg[ctrl.waddr] <= 1'b1;
            end
            rd_written_reg <= written_reg[ctrl.raddr] || bypass;
            rd_addr_reg    <= ctrl.raddr;
        end
    end

    assign head_entry = rd_written_reg ? rd_data_reg : rd_addr_reg;

endmodule

// ===== rtl/fha_engine.sv =====
// Open and close decision logic with the queue pointers, count and in-use map.
`timescale 1ns / 1ps

module fha_engine (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                fire,
    input  fha_pkg::req_type_t                  req_type,
    input  logic signed [fha_pkg::HANDLE_W-1:0] handle,
    input  logic [fha_pkg::BASE_W-1:0]          handle_base,
    output logic signed [fha_pkg::HANDLE_W-1:0] handle_out,
    output fha_pkg::status_t                    status
);

    fha_pkg::idx_t                      head_reg, head_next;
    fha_pkg::idx_t                      tail_reg, tail_next;
    logic [fha_pkg::CNT_W-1:0]          count_reg, count_next;
    logic [fha_pkg::HANDLE_COUNT-1:0]   in_use_reg, in_use_next;
    fha_pkg::idx_t                      head_entry;
    fha_pkg::fq_ctrl_t                  fq_ctrl;
    logic [fha_pkg::HANDLE_W-1:0]       base_ext;
    logic [fha_pkg::HANDLE_W-1:0]       offset;
    fha_pkg::idx_t                      close_idx;
    logic                               is_close;
    logic                               open_ok;
    logic                               close_ok;
    logic                               pop;
    logic                               push;

    localparam fha_pkg::idx_t LAST_IDX = fha_pkg::IDX_W'(fha_pkg::HANDLE_COUNT - 1);

    // Map the handle back to a pool index and check it.
    assign base_ext  = {1'b0, handle_base};
    assign offset    = $unsigned(handle) - base_ext;
    assign close_idx = offset[fha_pkg::IDX_W-1:0];
    assign is_close  = (req_type == fha_pkg::REQ_CLOSE);
    assign open_ok   = (count_reg != '0);
    assign close_ok  = (offset < fha_pkg::HANDLE_W'(fha_pkg::HANDLE_COUNT))
                       && in_use_reg[close_idx]
                       && (count_reg < fha_pkg::CNT_W'(fha_pkg::HANDLE_COUNT));
    assign pop       = fire && !is_close && open_ok;
    assign push      = fire && is_close && close_ok;

    // Result of the request.
    always_comb
    begin
        if (is_close)
        begin
            handle_out = handle;
            status     = close_ok ? fha_pkg::ST_OK : fha_pkg::ST_INVALID;
        end
        else if (open_ok)
        begin
            handle_out = $signed(base_ext + fha_pkg::HANDLE_W'(head_entry));
            status     = fha_pkg::ST_OK;
        end
        else
        begin
            handle_out = '1;
            status     = fha_pkg::ST_NO_RESOURCE;
        end
    end

    // Pointer, count and map updates.
    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        in_use_next = in_use_reg;
        if (pop)
        begin
            head_next               = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
            count_next              = count_reg - 1'b1;
            in_use_next[head_entry] = 1'b1;
        end
        if (push)
        begin
            tail_next              = (tail_reg == LAST_IDX) ? '0 : tail_reg + 1'b1;
            count_next             = count_reg + 1'b1;
            in_use_next[close_idx] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            tail_reg   <= '0;
            count_reg  <= fha_pkg::CNT_W'(fha_pkg::HANDLE_COUNT);
            in_use_reg <= '0;
        end
        else
        begin
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            count_reg  <= count_next;
            in_use_reg <= in_use_next;
        end
    end

    // The store is read at the head that the next request will see.
    assign fq_ctrl.push  = push;
    assign fq_ctrl.waddr = tail_reg;
    assign fq_ctrl.wdata = close_idx;
    assign fq_ctrl.raddr = head_next;

    fha_free_queue u_free_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (fq_ctrl),
        .head_entry (head_entry)
    );

endmodule

// ===== rtl/fifo_handle_allocator_top.sv =====
// Top level of the handle allocator: request register, engine and response register.
//
// Requests arrive on the req channel (valid/ready); a transfer carries req_type and
// handle. Each request yields exactly one response on the rsp channel with
// handle_out and status, in request order.
// A taken request waits in the request register until the response register is free
// or being emptied; then it is processed and the response register is loaded.
// One request can be taken every cycle while the receiver takes responses; the pool
// state (head, tail, count, in-use map) is updated in the same cycle that a request
// is processed; the free queue head entry is read ahead at a registered read port.
// If the receiver stalls, the response holds and one further request waits in the
// request register; req.ready then drops until the response is taken.
// Reset clears both registers, fills the pool with indices 0 to HANDLE_COUNT-1 in
// order, clears the in-use map and sets handle_base to zero; no clearing pass is
// needed, so requests are taken right after reset. handle_base is to be written
// via cfg_wr_en/cfg_wr_data only while the block is idle; it does not enforce this.
`timescale 1ns / 1ps

module fifo_handle_allocator_top (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [fha_pkg::BASE_W-1:0] cfg_wr_data,
    fha_req_if.sink                    req,
    fha_rsp_if.source                  rsp
);

    logic [fha_pkg::BASE_W-1:0]          base_reg;
    logic                                in_valid_reg;
    fha_pkg::req_type_t                  in_type_reg;
    logic signed [fha_pkg::HANDLE_W-1:0] in_handle_reg;
    logic                                out_valid_reg;
    logic signed [fha_pkg::HANDLE_W-1:0] out_handle_reg;
    fha_pkg::status_t                    out_status_reg;
    logic signed [fha_pkg::HANDLE_W-1:0] eng_handle;
    fha_pkg::status_t                    eng_status;
    logic                                advance;
    logic                                req_take;

    // A request moves on when the response register is free or being emptied.
    assign advance  = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;
    assign req_take = req.valid && req.ready;

    // Handle base register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            base_reg <= cfg_wr_data;
        end
    end

    // Request register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            in_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            in_type_reg   <= req.req_type;
            in_handle_reg <= req.handle;
        end
    end

    fha_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (advance),
        .req_type    (in_type_reg),
        .handle      (in_handle_reg),
        .handle_base (base_reg),
        .handle_out  (eng_handle),
        .status      (eng_status)
    );

    // Response register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_handle_reg <= eng_handle;
            out_status_reg <= eng_status;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.handle_out = out_handle_reg;
    assign rsp.status     = out_status_reg;

endmodule

// ===== rtl/fha_checker.sv =====
// Port-level checker of the handle allocator and its binding to the top level.
`timescale 1ns / 1ps
`include "fifo_handle_allocator_top_assert.svh"

module fha_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                req_valid,
    input logic                                req_ready,
    input logic                                rsp_valid,
    input logic                                rsp_ready,
    input logic signed [fha_pkg::HANDLE_W-1:0] rsp_handle_out,
    input fha_pkg::status_t                    rsp_status
);

    // A stalled response stays offered and unchanged.
    `FHA_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid)
    `FHA_ASSERT_NEXT(a_rsp_stable, clk, rst_n, rsp_valid && !rsp_ready, $stable(rsp_handle_out) && $stable(rsp_status))

    // Every request transfer must be followed by an offered response.
    `FHA_ASSERT_NEXT(a_req_answered, clk, rst_n, req_valid && req_ready, ##1 rsp_valid)

    // A failed open always returns the all-ones handle.
    `FHA_ASSERT(a_fail_handle, clk, rst_n, !(rsp_valid && (rsp_status == fha_pkg::ST_NO_RESOURCE)) || (rsp_handle_out == -32'sd1))

endmodule

bind fifo_handle_allocator_top fha_checker u_fha_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_handle_out (rsp.handle_out),
    .rsp_status     (rsp.status)
);
